### rtl/core/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned KindWidth  = 3;
   localparam int unsigned LenWidth   = 28;
   localparam int unsigned TickWidth  = 32;
   localparam int unsigned TempoWidth = 24;

   localparam logic [KindWidth-1:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [KindWidth-1:0] KIND_TEMPO    = 3'd2;
   localparam logic [KindWidth-1:0] KIND_TIME_SIG = 3'd3;
   localparam logic [KindWidth-1:0] KIND_NO_STAT  = 3'd4;

   localparam logic [7:0] STATUS_META    = 8'hFF;
   localparam logic [7:0] STATUS_SYSTEM  = 8'hF0;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] META_TIME_SIG  = 8'h58;
   localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
   localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
   localparam logic [3:0] MSG_PROGRAM    = 4'hC;
   localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;

   typedef enum logic [8:0] {
      PH_DELTA     = 9'b0_0000_0001,
      PH_STATUS    = 9'b0_0000_0010,
      PH_DATA1     = 9'b0_0000_0100,
      PH_DATA2     = 9'b0_0000_1000,
      PH_META_TYPE = 9'b0_0001_0000,
      PH_META_LEN  = 9'b0_0010_0000,
      PH_META_DATA = 9'b0_0100_0000,
      PH_SYS_LEN   = 9'b0_1000_0000,
      PH_SKIP      = 9'b1_0000_0000
   } phase_type;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [TickWidth-1:0]  tick_time;
      logic [3:0]            channel;
      logic [6:0]            note;
      logic [6:0]            velocity;
      logic [TempoWidth-1:0] tempo_us;
      logic [7:0]            sig_numerator;
      logic [7:0]            sig_denominator_log2;
   } result_type;

endpackage

### rtl/core/mtep_decode.sv
// ----------------------------------------------------------------------------
// mtep_decode
// Parser state and one-byte decode step; state advances on fire.
// ----------------------------------------------------------------------------
module mtep_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 track_start,
   input  logic [7:0]           byte_in,
   output logic                 emit,
   output mtep_pkg::result_type result
);
   import mtep_pkg::*;

   phase_type                phase_ff,     phase_in,     phase_eff;
   logic [7:0]               rstat_ff,     rstat_in,     rstat_eff;
   logic [LenWidth-1:0]      delta_ff,     delta_in,     delta_eff;
   logic [TickWidth-1:0]     ticks_ff,     ticks_in,     ticks_eff;
   logic [7:0]               meta_ff,      meta_in,      meta_eff;
   logic [LenWidth-1:0]      left_ff,      left_in,      left_eff;
   logic [1:0]               index_ff,     index_in,     index_eff;
   logic [7:0]               first_ff,     first_in,     first_eff;
   logic [TempoWidth-1:0]    pay_ff,       pay_in,       pay_eff;
   logic [LenWidth-1:0]      vlq_next;
   logic [LenWidth-1:0]      left_dec;
   logic [TempoWidth-1:0]    pay_next;
   logic [1:0]               index_next;
   logic [3:0]               msg_type;

   always_comb begin
      phase_eff = track_start ? PH_DELTA : phase_ff;
      rstat_eff = track_start ? 8'd0 : rstat_ff;
      delta_eff = track_start ? '0 : delta_ff;
      ticks_eff = track_start ? '0 : ticks_ff;
      meta_eff  = track_start ? 8'd0 : meta_ff;
      left_eff  = track_start ? '0 : left_ff;
      index_eff = track_start ? 2'd0 : index_ff;
      first_eff = track_start ? 8'd0 : first_ff;
      pay_eff   = track_start ? '0 : pay_ff;

      vlq_next   = {left_eff[LenWidth-8:0], byte_in[6:0]};
      left_dec   = left_eff - {{(LenWidth-1){1'b0}}, 1'b1};
      pay_next   = {pay_eff[TempoWidth-9:0], byte_in};
      index_next = index_eff + 2'd1;
      msg_type   = rstat_eff[7:4];

      phase_in = phase_eff;
      rstat_in = rstat_eff;
      delta_in = delta_eff;
      ticks_in = ticks_eff;
      meta_in  = meta_eff;
      left_in  = left_eff;
      index_in = index_eff;
      first_in = first_eff;
      pay_in   = pay_eff;

      emit             = 1'b0;
      result           = '0;
      result.tick_time = ticks_eff;

      unique case (phase_eff)
         PH_STATUS: begin
            if (byte_in[7]) begin
               if (byte_in == STATUS_META) begin
                  rstat_in = 8'd0;
                  phase_in = PH_META_TYPE;
               end else if (byte_in >= STATUS_SYSTEM) begin
                  rstat_in = 8'd0;
                  left_in  = '0;
                  phase_in = PH_SYS_LEN;
               end else begin
                  rstat_in = byte_in;
                  phase_in = PH_DATA1;
               end
            end else if (rstat_eff == 8'd0) begin
               emit        = 1'b1;
               result.kind = KIND_NO_STAT;
               phase_in    = PH_DELTA;
            end else begin
               first_in = {1'b0, byte_in[6:0]};
               phase_in = (msg_type == MSG_PROGRAM || msg_type == MSG_CHAN_PRESS)
                          ? PH_DELTA : PH_DATA2;
            end
         end
         PH_DATA1: begin
            first_in = {1'b0, byte_in[6:0]};
            phase_in = (msg_type == MSG_PROGRAM || msg_type == MSG_CHAN_PRESS)
                       ? PH_DELTA : PH_DATA2;
         end
         PH_DATA2: begin
            phase_in = PH_DELTA;
            if (msg_type == MSG_NOTE_ON || msg_type == MSG_NOTE_OFF) begin
               emit           = 1'b1;
               result.kind    = (msg_type == MSG_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
               result.channel = rstat_eff[3:0];
               result.note    = first_eff[6:0];
               result.velocity = (msg_type == MSG_NOTE_ON) ? byte_in[6:0] : 7'd0;
            end
         end
         PH_META_TYPE: begin
            meta_in  = byte_in;
            left_in  = '0;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN, PH_SYS_LEN: begin
            left_in = vlq_next;
            if (!byte_in[7]) begin
               if (vlq_next == '0) begin
                  phase_in = PH_DELTA;
               end else if (phase_eff == PH_META_LEN) begin
                  index_in = 2'd0;
                  pay_in   = '0;
                  phase_in = PH_META_DATA;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_META_DATA: begin
            if (index_eff != 2'd3) begin
               pay_in   = pay_next;
               index_in = index_next;
               if (meta_eff == META_TEMPO && index_next == 2'd3) begin
                  emit            = 1'b1;
                  result.kind     = KIND_TEMPO;
                  result.tempo_us = pay_next;
               end else if (meta_eff == META_TIME_SIG && index_next == 2'd1) begin
                  first_in = byte_in;
               end else if (meta_eff == META_TIME_SIG && index_next == 2'd2) begin
                  emit                        = 1'b1;
                  result.kind                 = KIND_TIME_SIG;
                  result.sig_numerator        = first_eff;
                  result.sig_denominator_log2 = byte_in;
               end
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_DELTA;
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_DELTA;
            end
         end
         default: begin
            delta_in = {delta_eff[LenWidth-8:0], byte_in[6:0]};
            phase_in = PH_DELTA;
            if (!byte_in[7]) begin
               ticks_in = ticks_eff + {{(TickWidth-LenWidth){1'b0}}, delta_in};
               delta_in = '0;
               phase_in = PH_STATUS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         rstat_ff <= 8'd0;
         delta_ff <= '0;
         ticks_ff <= '0;
         meta_ff  <= 8'd0;
         left_ff  <= '0;
         index_ff <= 2'd0;
         first_ff <= 8'd0;
         pay_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         rstat_ff <= rstat_in;
         delta_ff <= delta_in;
         ticks_ff <= ticks_in;
         meta_ff  <= meta_in;
         left_ff  <= left_in;
         index_ff <= index_in;
         first_ff <= first_in;
         pay_ff   <= pay_in;
      end
   end

endmodule

### rtl/core/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses track chunk body bytes into note, tempo and time-signature events.
//
// Input channel (req_): one track body byte per beat; req_track_start marks
// the first byte of a track and clears time and running status.
// Result channel (rsp_): at most one event per input byte; bytes that yield
// no event produce no beat.
// Each byte lands in an input register and is decoded from there. The event
// is written to the result register when the decode step fires, so a result
// is presented from that register. One byte per cycle is sustained while no
// result waits under rsp_stall: the decode step is the only loop.
// While a result waits under rsp_stall, the input register may fill once and
// then holds its byte, whether or not that byte gives an event; req_stall
// stays high until the waiting result beat is taken.
// Reset clears the parser state and the valid flags of both registers; time
// starts at zero with no running status.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_track_start,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_tick_time,
   output logic [3:0]  rsp_channel,
   output logic [6:0]  rsp_note,
   output logic [6:0]  rsp_velocity,
   output logic [23:0] rsp_tempo_us,
   output logic [7:0]  rsp_sig_numerator,
   output logic [7:0]  rsp_sig_denominator_log2
);
   import mtep_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_start_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type step_result;
   logic       step_emit;
   logic       advance;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   mtep_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .track_start (in_start_ff),
      .byte_in     (in_byte_ff),
      .emit        (step_emit),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_start_ff <= req_track_start;
         in_byte_ff  <= req_byte_in;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_kind                 = rsp_data_ff.kind;
   assign rsp_tick_time            = rsp_data_ff.tick_time;
   assign rsp_channel              = rsp_data_ff.channel;
   assign rsp_note                 = rsp_data_ff.note;
   assign rsp_velocity             = rsp_data_ff.velocity;
   assign rsp_tempo_us             = rsp_data_ff.tempo_us;
   assign rsp_sig_numerator        = rsp_data_ff.sig_numerator;
   assign rsp_sig_denominator_log2 = rsp_data_ff.sig_denominator_log2;

`ifndef SYNTHESIS
   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_note_off_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == KIND_NOTE_OFF) |-> rsp_data_ff.velocity == 7'd0)
      else $error("note off with nonzero velocity");

   a_emit_kind_known: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit) |=> (rsp_valid_ff && (rsp_data_ff.kind == KIND_NOTE_ON
         || rsp_data_ff.kind == KIND_NOTE_OFF || rsp_data_ff.kind == KIND_TEMPO
         || rsp_data_ff.kind == KIND_TIME_SIG || rsp_data_ff.kind == KIND_NO_STAT)))
      else $error("event not captured with a known kind");
`endif

endmodule

### sim/midi_event_checker.sv
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches both channels of the MIDI track event parser. Every byte taken on
// the input channel runs through a local track parser. The note, tempo,
// time-signature and missing-status events that it decodes are held in order.
// Every result beat is compared field by field against the oldest held event.
// ----------------------------------------------------------------------------
module midi_event_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_track_start,
   input  logic [7:0]  req_byte_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [31:0] rsp_tick_time,
   input  logic [3:0]  rsp_channel,
   input  logic [6:0]  rsp_note,
   input  logic [6:0]  rsp_velocity,
   input  logic [23:0] rsp_tempo_us,
   input  logic [7:0]  rsp_sig_numerator,
   input  logic [7:0]  rsp_sig_denominator_log2,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mtep_pkg::*;

   phase_type   phase;
   logic [7:0]  status_now;
   logic [27:0] delta_sum;
   logic [31:0] tick_now;
   logic [7:0]  meta_code;
   logic [27:0] remaining;
   logic [1:0]  payload_count;
   logic [7:0]  held_data;
   logic [23:0] payload_acc;

   result_type  pending_events[$];
   int          failures = 0;
   int          waiting = 0;

   assign fail_count    = failures;
   assign pending_count = waiting;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: event mismatch on %s: got %0h, want %0h", $time, what, got, want);
      failures++;
   endtask

   task automatic clear_parser();
      phase         = PH_DELTA;
      status_now    = '0;
      delta_sum     = '0;
      tick_now      = '0;
      meta_code     = '0;
      remaining     = '0;
      payload_count = '0;
      held_data     = '0;
      payload_acc   = '0;
   endtask

   task automatic parse_byte(input logic start, input logic [7:0] b);
      result_type ev;
      logic       hit;
      logic [3:0] msg;
      hit = 1'b0;
      if (start) clear_parser();
      ev = '0;
      ev.tick_time = tick_now;
      msg = status_now[7:4];
      // reuse running status: data byte in place of a status
      if (phase == PH_STATUS && !b[7] && status_now != 8'h00) phase = PH_DATA1;
      case (phase)
         PH_STATUS: begin
            if (!b[7]) begin
               ev.kind = KIND_NO_STAT;
               hit = 1'b1;
               phase = PH_DELTA;
            end else if (b == STATUS_META) begin
               status_now = '0;
               phase = PH_META_TYPE;
            end else if (b >= STATUS_SYSTEM) begin
               status_now = '0;
               remaining = '0;
               phase = PH_SYS_LEN;
            end else begin
               status_now = b;
               phase = PH_DATA1;
            end
         end
         PH_DATA1: begin
            held_data = {1'b0, b[6:0]};
            phase = (msg == MSG_PROGRAM || msg == MSG_CHAN_PRESS) ? PH_DELTA : PH_DATA2;
         end
         PH_DATA2: begin
            phase = PH_DELTA;
            if (msg == MSG_NOTE_ON || msg == MSG_NOTE_OFF) begin
               ev.kind     = (msg == MSG_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
               ev.channel  = status_now[3:0];
               ev.note     = held_data[6:0];
               ev.velocity = (msg == MSG_NOTE_ON) ? b[6:0] : 7'd0;
               hit = 1'b1;
            end
         end
         PH_META_TYPE: begin
            meta_code = b;
            remaining = '0;
            phase = PH_META_LEN;
         end
         PH_META_LEN, PH_SYS_LEN: begin
            remaining = {remaining[20:0], b[6:0]};
            if (!b[7]) begin
               if (remaining == '0) begin
                  phase = PH_DELTA;
               end else if (phase == PH_META_LEN) begin
                  payload_count = '0;
                  payload_acc = '0;
                  phase = PH_META_DATA;
               end else begin
                  phase = PH_SKIP;
               end
            end
         end
         PH_META_DATA: begin
            if (payload_count != 2'd3) begin
               payload_acc = {payload_acc[15:0], b};
               payload_count = payload_count + 2'd1;
               if (meta_code == META_TEMPO && payload_count == 2'd3) begin
                  ev.kind = KIND_TEMPO;
                  ev.tempo_us = payload_acc;
                  hit = 1'b1;
               end else if (meta_code == META_TIME_SIG && payload_count == 2'd1) begin
                  held_data = b;
               end else if (meta_code == META_TIME_SIG && payload_count == 2'd2) begin
                  ev.kind = KIND_TIME_SIG;
                  ev.sig_numerator = held_data;
                  ev.sig_denominator_log2 = b;
                  hit = 1'b1;
               end
            end
            remaining = remaining - 28'd1;
            if (remaining == '0) phase = PH_DELTA;
         end
         PH_SKIP: begin
            remaining = remaining - 28'd1;
            if (remaining == '0) phase = PH_DELTA;
         end
         default: begin
            delta_sum = {delta_sum[20:0], b[6:0]};
            phase = PH_DELTA;
            if (!b[7]) begin
               tick_now = tick_now + 32'(delta_sum);
               delta_sum = '0;
               phase = PH_STATUS;
            end
         end
      endcase
      if (hit) pending_events.push_back(ev);
   endtask

   task automatic check_event();
      result_type want;
      if (pending_events.size() == 0) begin
         report_mismatch("beat with no event pending, kind", 32'(rsp_kind), 32'd0);
      end else begin
         want = pending_events.pop_front();
         if (rsp_kind !== want.kind)
            report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
         if (rsp_tick_time !== want.tick_time)
            report_mismatch("tick_time", rsp_tick_time, want.tick_time);
         if (rsp_channel !== want.channel)
            report_mismatch("channel", 32'(rsp_channel), 32'(want.channel));
         if (rsp_note !== want.note)
            report_mismatch("note", 32'(rsp_note), 32'(want.note));
         if (rsp_velocity !== want.velocity)
            report_mismatch("velocity", 32'(rsp_velocity), 32'(want.velocity));
         if (rsp_tempo_us !== want.tempo_us)
            report_mismatch("tempo_us", 32'(rsp_tempo_us), 32'(want.tempo_us));
         if (rsp_sig_numerator !== want.sig_numerator)
            report_mismatch("sig_numerator", 32'(rsp_sig_numerator),
                            32'(want.sig_numerator));
         if (rsp_sig_denominator_log2 !== want.sig_denominator_log2)
            report_mismatch("sig_denominator_log2", 32'(rsp_sig_denominator_log2),
                            32'(want.sig_denominator_log2));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         pending_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_event();
         if (req_valid && !req_stall) parse_byte(req_track_start, req_byte_in);
      end
      waiting = pending_events.size();
   end

endmodule

### sim/midi_track_event_parser_tb.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// Feeds the MIDI track event parser a byte stream. A short hand-built track
// comes first. It is followed by random tracks that are made mostly of
// well-formed events, with stray bytes, noise and restarts mixed in. Both
// channels idle at random. The checker predicts and compares every event beat.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtep_pkg::*;

   localparam logic [3:0] MSG_POLY_PRESS = 4'hA;
   localparam logic [3:0] MSG_CONTROL    = 4'hB;
   localparam logic [3:0] MSG_PITCH_BEND = 4'hE;
   localparam int         RANDOM_BYTES   = 1450;
   localparam int         STALL_LIMIT    = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_track_start = 1'b0;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_tick_time;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_note;
   logic [6:0]  rsp_velocity;
   logic [23:0] rsp_tempo_us;
   logic [7:0]  rsp_sig_numerator;
   logic [7:0]  rsp_sig_denominator_log2;

   int          fail_count;
   int          pending_count;
   logic [8:0]  stream_bytes[$];
   int          next_pos = 0;
   int          cycle_count = 0;
   int          quiet_cycles = 0;
   logic        next_start;
   logic [7:0]  gen_status;
   logic        quiet;

   always #1 clock = ~clock;

   midi_track_event_parser dut (.*);

   midi_event_checker checker_i (.*);

   task automatic put(input logic [7:0] b);
      stream_bytes.push_back({next_start || ($urandom_range(199) == 0), b});
      next_start = 1'b0;
   endtask

   task automatic put_vlq(input logic [34:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) put({i != 0, v[7 * i +: 7]});
   endtask

   task automatic add_random_event();
      int         pick;
      int         len;
      logic [3:0] msg;
      logic [7:0] meta;
      if ($urandom_range(99) < 3) begin
         next_start = 1'b1;
         gen_status = '0;
      end
      put_vlq(35'({$urandom, $urandom}), ($urandom_range(9) < 6) ? 1 : $urandom_range(1, 5));
      pick = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(9))
            0: msg = MSG_POLY_PRESS;
            1: msg = MSG_CONTROL;
            2: msg = MSG_PROGRAM;
            3: msg = MSG_CHAN_PRESS;
            4: msg = MSG_PITCH_BEND;
            5, 6: msg = MSG_NOTE_OFF;
            default: msg = MSG_NOTE_ON;
         endcase
         if (gen_status[7:4] != msg || $urandom_range(2) == 0) begin
            gen_status = {msg, 4'($urandom)};
            put(gen_status);
         end
         len = (msg == MSG_PROGRAM || msg == MSG_CHAN_PRESS) ? 1 : 2;
         repeat (len) put(($urandom_range(19) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)});
      end else if (pick < 85) begin
         gen_status = '0;
         if (pick < 80) begin
            put(STATUS_META);
            case ($urandom_range(2))
               0: meta = META_TEMPO;
               1: meta = META_TIME_SIG;
               default: meta = 8'($urandom);
            endcase
            put(meta);
            if (meta != META_TEMPO && meta != META_TIME_SIG || $urandom_range(3) == 0)
               len = $urandom_range(0, 6);
            else
               len = (meta == META_TEMPO) ? 3 : 4;
         end else begin
            put(8'($urandom_range(8'hF0, 8'hFE)));
            len = $urandom_range(0, 5);
         end
         put_vlq(35'(len), ($urandom_range(4) == 0) ? 2 : 1);
         repeat (len) put(8'($urandom));
      end else if (pick < 93) begin
         put({1'b0, 7'($urandom)});
      end else begin
         repeat ($urandom_range(1, 3)) put(8'($urandom));
      end
   endtask

   assign quiet = cycle_count >= 1000 && cycle_count < 1600;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 37);
         if (!req_valid || !req_stall) begin
            if (next_pos < stream_bytes.size() && (quiet || $urandom_range(99) >= 37)) begin
               req_valid <= 1'b1;
               {req_track_start, req_byte_in} <= stream_bytes[next_pos];
               next_pos <= next_pos + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      gen_status = '0;
      next_start = 1'b1;
      // missing status, then a five-byte delta
      put(8'h00);
      put(8'h40);
      put_vlq(35'h7_FFFF_FFFF, 5);
      // note on with status bits in the data, then running status with velocity zero
      put({MSG_NOTE_ON, 4'hF});
      put(8'hFF);
      put(8'hFF);
      put(8'h00);
      put(8'h00);
      put(8'h00);
      put(8'h00);
      put({MSG_NOTE_OFF, 4'h0});
      put(8'h3C);
      put(8'h7F);
      // full tempo, time signature with extra bytes, short tempo
      put(8'h00);
      put(STATUS_META);
      put(META_TEMPO);
      put(8'h03);
      repeat (3) put(8'hFF);
      put(8'h00);
      put(STATUS_META);
      put(META_TIME_SIG);
      put(8'h05);
      put(8'hFF);
      put(8'h00);
      put(8'h18);
      put(8'h08);
      put(8'h00);
      put(8'h00);
      put(STATUS_META);
      put(META_TEMPO);
      put(8'h02);
      put(8'h07);
      put(8'hA1);
      // skipped channel messages, then sysex that drops running status
      put(8'h00);
      put({MSG_PROGRAM, 4'h5});
      put(8'h10);
      put(8'h00);
      put({MSG_PITCH_BEND, 4'h3});
      put(8'h00);
      put(8'h40);
      put(8'h00);
      put(STATUS_SYSTEM);
      put(8'h02);
      put(8'h11);
      put(8'hF7);
      put(8'h00);
      put(8'h42);
      while (stream_bytes.size() < 52 + RANDOM_BYTES) add_random_event();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (next_pos < stream_bytes.size() || req_valid);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
